>>> rtl/tli_pkg.sv
package tli_pkg;

  // Field widths
  localparam int CORNER_W     = 16;
  localparam int FRAC_W       = 8;
  localparam int VALUE_W      = 40;
  localparam int GRAD_W       = 33;

  // Internal widths: axis weight 0..256, weight pair 0..65536,
  // corner times weight pair below 2^32, signed lane gradient term
  localparam int WEIGHT_W     = 9;
  localparam int PAIR_W       = 17;
  localparam int PART_W       = 33;
  localparam int GSUM_W       = 34;

  localparam int NUM_CORNERS  = 8;
  localparam int AXES_MAX     = 3;
  localparam int NUM_AXES_DEF = 3;

  localparam logic [WEIGHT_W-1:0] ONE_Q8 = WEIGHT_W'(256);

  typedef logic        [VALUE_W-1:0] value_t;
  typedef logic signed [GSUM_W-1:0]  gsum_t;
  typedef logic signed [GRAD_W-1:0]  grad_t;

  // Load enables of the lane stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_en_t;

  // Load enables of the adder tree levels
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
  } merge_en_t;

  // Linear weight of one side of an axis: near = 256 - f, far = f
  function automatic logic [WEIGHT_W-1:0] side_weight(input logic [FRAC_W-1:0] f,
                                                      input logic far_side);
    return far_side ? {1'b0, f} : ONE_Q8 - {1'b0, f};
  endfunction

endpackage

>>> rtl/tli_lane.sv
module tli_lane
  import tli_pkg::*;
#(
  parameter logic [2:0] CORNER = 3'd0
) (
  input  logic                clk,
  input  lane_en_t            en,
  input  logic [CORNER_W-1:0] corner,
  input  logic [FRAC_W-1:0]   frac_x,
  input  logic [FRAC_W-1:0]   frac_y,
  input  logic [FRAC_W-1:0]   frac_z,
  output value_t              val,
  output gsum_t               grad_x,
  output gsum_t               grad_y,
  output gsum_t               grad_z
);

  logic [WEIGHT_W-1:0] wx, wy, wz;
  logic [PAIR_W-1:0]   wxy_nxt, wxz_nxt, wyz_nxt;

  logic [CORNER_W-1:0] c1_r;
  logic [PAIR_W-1:0]   wxy_r, wxz_r, wyz_r;
  logic [WEIGHT_W-1:0] wz1_r;

  logic [PART_W-1:0]   px_nxt, py_nxt, pz_nxt;
  logic [PART_W-1:0]   px_r, py_r, pz_r;
  logic [WEIGHT_W-1:0] wz2_r;

  value_t              val_nxt;
  gsum_t               mx, my, mz;
  value_t              val_r;
  gsum_t               gx_r, gy_r, gz_r;

  // Weights of this corner and their pairwise products
  always_comb begin
    wx      = side_weight(frac_x, CORNER[0]);
    wy      = side_weight(frac_y, CORNER[1]);
    wz      = side_weight(frac_z, CORNER[2]);
    wxy_nxt = PAIR_W'(wx) * PAIR_W'(wy);
    wxz_nxt = PAIR_W'(wx) * PAIR_W'(wz);
    wyz_nxt = PAIR_W'(wy) * PAIR_W'(wz);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      c1_r  <= corner;
      wxy_r <= wxy_nxt;
      wxz_r <= wxz_nxt;
      wyz_r <= wyz_nxt;
      wz1_r <= wz;
    end
  end

  // Corner times the weight pair of the two other axes
  always_comb begin
    px_nxt = PART_W'(c1_r) * PART_W'(wyz_r);
    py_nxt = PART_W'(c1_r) * PART_W'(wxz_r);
    pz_nxt = PART_W'(c1_r) * PART_W'(wxy_r);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      pz_r  <= pz_nxt;
      wz2_r <= wz1_r;
    end
  end

  // Full weight for the value, difference sign for the gradients
  always_comb begin
    val_nxt = VALUE_W'(VALUE_W'(pz_r) * VALUE_W'(wz2_r));
    mx      = GSUM_W'(px_r);
    my      = GSUM_W'(py_r);
    mz      = GSUM_W'(pz_r);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      val_r <= val_nxt;
      gx_r  <= CORNER[0] ? mx : -mx;
      gy_r  <= CORNER[1] ? my : -my;
      gz_r  <= CORNER[2] ? mz : -mz;
    end
  end

  assign val    = val_r;
  assign grad_x = gx_r;
  assign grad_y = gy_r;
  assign grad_z = gz_r;

endmodule

>>> rtl/tli_merge.sv
module tli_merge
  import tli_pkg::*;
#(
  parameter int NUM_AXES = NUM_AXES_DEF
) (
  input  logic      clk,
  input  merge_en_t en,
  input  value_t    val  [NUM_CORNERS],
  input  gsum_t     grad [NUM_CORNERS][AXES_MAX],
  output value_t    interp_value,
  output grad_t     grad_out [AXES_MAX]
);

  value_t v4_r [4];
  gsum_t  g4_r [4][AXES_MAX];
  value_t v5_r [2];
  gsum_t  g5_r [2][AXES_MAX];
  value_t v6_r;
  grad_t  g6_r [AXES_MAX];

  // First level: pairs of lanes
  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int j = 0; j < 4; j++) begin
        v4_r[j] <= val[2*j] + val[2*j+1];
        for (int a = 0; a < AXES_MAX; a++) begin
          g4_r[j][a] <= grad[2*j][a] + grad[2*j+1][a];
        end
      end
    end
  end

  // Second level
  always_ff @(posedge clk) begin
    if (en.s5) begin
      for (int j = 0; j < 2; j++) begin
        v5_r[j] <= v4_r[2*j] + v4_r[2*j+1];
        for (int a = 0; a < AXES_MAX; a++) begin
          g5_r[j][a] <= g4_r[2*j][a] + g4_r[2*j+1][a];
        end
      end
    end
  end

  // Final sum; drop the derivative of an inactive axis
  always_ff @(posedge clk) begin
    if (en.s6) begin
      v6_r <= v5_r[0] + v5_r[1];
      for (int a = 0; a < AXES_MAX; a++) begin
        if (a < NUM_AXES) begin
          g6_r[a] <= GRAD_W'(g5_r[0][a] + g5_r[1][a]);
        end else begin
          g6_r[a] <= '0;
        end
      end
    end
  end

  assign interp_value = v6_r;
  assign grad_out     = g6_r;

endmodule

>>> rtl/trilinear_interp_with_gradient_top.sv
// Trilinear interpolation with gradient. Each item carries the eight corner
// samples of a unit cube and a Q0.8 position; the result is the interpolated
// value scaled by 2^24 and the three partial derivatives scaled by 2^16,
// exact with no rounding or saturation. Eight corner lanes each form their
// weighted terms over three multiplier stages, and a three-level registered
// adder tree merges them. The block takes one item per cycle while in_stall is
// low; every stage has its own valid bit, so empty stages keep filling while a
// finished result waits under out_stall. Axes at or beyond NUM_AXES behave as
// if their fraction were zero and report a zero derivative.
module trilinear_interp_with_gradient_top
  import tli_pkg::*;
#(
  parameter int NUM_AXES = NUM_AXES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CORNER_W-1:0]        in_corner_000,
  input  logic [CORNER_W-1:0]        in_corner_001,
  input  logic [CORNER_W-1:0]        in_corner_010,
  input  logic [CORNER_W-1:0]        in_corner_011,
  input  logic [CORNER_W-1:0]        in_corner_100,
  input  logic [CORNER_W-1:0]        in_corner_101,
  input  logic [CORNER_W-1:0]        in_corner_110,
  input  logic [CORNER_W-1:0]        in_corner_111,
  input  logic [FRAC_W-1:0]          in_frac_x,
  input  logic [FRAC_W-1:0]          in_frac_y,
  input  logic [FRAC_W-1:0]          in_frac_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [VALUE_W-1:0]         out_interp_value,
  output logic signed [GRAD_W-1:0]   out_grad_x,
  output logic signed [GRAD_W-1:0]   out_grad_y,
  output logic signed [GRAD_W-1:0]   out_grad_z
);

  localparam int STAGES = 7;

  logic [STAGES-1:0]   vld_r, vld_nxt, rdy;
  lane_en_t            lane_en;
  merge_en_t           merge_en;

  logic [CORNER_W-1:0] corner_in [NUM_CORNERS];
  logic [CORNER_W-1:0] c0_r      [NUM_CORNERS];
  logic [FRAC_W-1:0]   fx0_r, fy0_r, fz0_r;

  value_t              lane_val  [NUM_CORNERS];
  gsum_t               lane_grad [NUM_CORNERS][AXES_MAX];
  value_t              sum_val;
  grad_t               sum_grad  [AXES_MAX];

  // A stage loads when it is empty or its successor loads
  always_comb begin
    rdy[STAGES-1] = !vld_r[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < STAGES; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[STAGES-1];

  assign lane_en  = '{s1: rdy[1], s2: rdy[2], s3: rdy[3]};
  assign merge_en = '{s4: rdy[4], s5: rdy[5], s6: rdy[6]};

  // Input register; an inactive axis sits at fraction zero
  assign corner_in[0] = in_corner_000;
  assign corner_in[1] = in_corner_001;
  assign corner_in[2] = in_corner_010;
  assign corner_in[3] = in_corner_011;
  assign corner_in[4] = in_corner_100;
  assign corner_in[5] = in_corner_101;
  assign corner_in[6] = in_corner_110;
  assign corner_in[7] = in_corner_111;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c0_r  <= corner_in;
      fx0_r <= (NUM_AXES > 0) ? in_frac_x : '0;
      fy0_r <= (NUM_AXES > 1) ? in_frac_y : '0;
      fz0_r <= (NUM_AXES > 2) ? in_frac_z : '0;
    end
  end

  // One lane per corner
  for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_lane
    tli_lane #(
      .CORNER (3'(i))
    ) u_lane (
      .clk    (clk),
      .en     (lane_en),
      .corner (c0_r[i]),
      .frac_x (fx0_r),
      .frac_y (fy0_r),
      .frac_z (fz0_r),
      .val    (lane_val[i]),
      .grad_x (lane_grad[i][0]),
      .grad_y (lane_grad[i][1]),
      .grad_z (lane_grad[i][2])
    );
  end

  tli_merge #(
    .NUM_AXES (NUM_AXES)
  ) u_merge (
    .clk          (clk),
    .en           (merge_en),
    .val          (lane_val),
    .grad         (lane_grad),
    .interp_value (sum_val),
    .grad_out     (sum_grad)
  );

  assign out_interp_value = sum_val;
  assign out_grad_x       = sum_grad[0];
  assign out_grad_y       = sum_grad[1];
  assign out_grad_z       = sum_grad[2];

endmodule
